// ----- rtl/core/htd_pkg.sv -----
package htd_pkg;

   // defaults for the top level parameters
   localparam int NODE_COUNT_DEF  = 64;
   localparam int SYMBOL_BITS_DEF = 8;

   // fixed field widths
   localparam int IDX_W  = 6;
   localparam int SYM_W  = 8;
   localparam int CNT_W  = 12;
   localparam int KIND_W = 2;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // depth of the queues between front, back and result port
   localparam int QUEUE_DEPTH = 2;

   // request codes on the req_type field
   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_BIT   = 2'd1,
      REQ_END   = 2'd2
   } req_code_type;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_SYMBOL = 2'd0,
      KIND_ERROR  = 2'd1,
      KIND_END    = 2'd2
   } kind_type;

   // classified operations handed from front to back
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_BIT   = 2'd1,
      OP_END   = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [IDX_W-1:0] node_index;
      logic [IDX_W-1:0] left_index;
      logic             left_present;
      logic [IDX_W-1:0] right_index;
      logic             right_present;
      logic             node_leaf;
      logic [SYM_W-1:0] node_symbol;
      logic             code_bit;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0] result_kind;
      logic [SYM_W-1:0]  symbol;
      logic [CNT_W-1:0]  symbol_count;
   } rsp_item_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] node_index;
      logic [IDX_W-1:0] left_index;
      logic             left_present;
      logic [IDX_W-1:0] right_index;
      logic             right_present;
      logic             node_leaf;
      logic [SYM_W-1:0] node_symbol;
      logic             code_bit;
   } cmd_item_type;

endpackage

// ----- rtl/core/huffman_tree_decoder_core.sv -----
// Huffman tree-walk decoder. Node writes load a node table (children with
// present flags, leaf flag, symbol); code-bit items walk it from the root,
// and each leaf reached gives a symbol result with the running symbol count
// (saturating at 4095), a missing child gives an error result, and an end
// item reports the count and restarts the message. A front stage classifies
// items and drops unknown codes and out-of-range node writes, a two-entry
// queue decouples it from the walk engine, and a two-entry result queue sits
// in front of the result port. Node writes and end items are handled in the
// idle state. A code bit inside the tree issues a registered read of the
// child entry and acts on it in the child state; it is handled in the idle
// state when the cached node is a leaf or lacks the chosen child. After a
// return to the root the root entry is read and loaded into the cache first.
// The node table has a single read port with registered read data; a result
// also waits while the result queue is full. A root change written on the
// csr port takes effect at the next return to the root. No clearing pass is
// done after reset.
module huffman_tree_decoder_core #(
   parameter int NODE_COUNT  = htd_pkg::NODE_COUNT_DEF,
   parameter int SYMBOL_BITS = htd_pkg::SYMBOL_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request queue side
   input  logic                      push,
   input  htd_pkg::req_item_type     req_data,
   output logic                      full,
   // result queue side
   output logic                      empty,
   input  logic                      pop,
   output htd_pkg::rsp_item_type     rsp_data,
   // root index register
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [htd_pkg::IDX_W-1:0] csr_data
);

   localparam int CmdW = $bits(htd_pkg::cmd_item_type);
   localparam int RspW = $bits(htd_pkg::rsp_item_type);

   // front to queue
   logic                  cmd_push;
   htd_pkg::cmd_item_type cmd_in_item;
   logic                  cmd_full;
   // queue to back
   logic [CmdW-1:0]       cmd_out_bits;
   htd_pkg::cmd_item_type cmd_out_item;
   logic                  cmd_empty;
   logic                  cmd_pop;
   // back to result queue
   logic                  rsp_push;
   htd_pkg::rsp_item_type rsp_in_item;
   logic                  rsp_full;
   logic [RspW-1:0]       rsp_out_bits;

   // the user writes the register only while the block is idle; the block itself does not enforce this
   assign csr_ready    = 1'b1;
   assign cmd_out_item = htd_pkg::cmd_item_type'(cmd_out_bits);
   assign rsp_data     = htd_pkg::rsp_item_type'(rsp_out_bits);

   // classify and filter incoming items
   htd_front #(
      .NODE_COUNT (NODE_COUNT)
   ) u_front (
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .cmd_push (cmd_push),
      .cmd_item (cmd_in_item),
      .cmd_full (cmd_full)
   );

   // decoupling queue between front and walk engine
   htd_fifo #(
      .WIDTH (CmdW),
      .DEPTH (htd_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (CmdW'(cmd_in_item)),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_bits),
      .empty     (cmd_empty)
   );

   // walk engine with the node table and the cached current node
   htd_back #(
      .NODE_COUNT  (NODE_COUNT),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd_item  (cmd_out_item),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_in_item),
      .rsp_full  (rsp_full),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_data)
   );

   // result queue, lets the engine go on while a result waits
   htd_fifo #(
      .WIDTH (RspW),
      .DEPTH (htd_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (RspW'(rsp_in_item)),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_out_bits),
      .empty     (empty)
   );

endmodule

// ----- rtl/core/htd_fifo.sv -----
module htd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = htd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/htd_front.sv -----
module htd_front #(
   parameter int NODE_COUNT = htd_pkg::NODE_COUNT_DEF
) (
   input  logic                  push,
   input  htd_pkg::req_item_type req_data,
   output logic                  full,
   output logic                  cmd_push,
   output htd_pkg::cmd_item_type cmd_item,
   input  logic                  cmd_full
);

   logic accept;
   logic in_range;

   assign full     = cmd_full;
   assign accept   = push && !cmd_full;
   assign in_range = (32'(req_data.node_index) < NODE_COUNT);

   always_comb begin
      cmd_item.op            = htd_pkg::OP_WRITE;
      cmd_item.node_index    = req_data.node_index;
      cmd_item.left_index    = req_data.left_index;
      cmd_item.left_present  = req_data.left_present;
      cmd_item.right_index   = req_data.right_index;
      cmd_item.right_present = req_data.right_present;
      cmd_item.node_leaf     = req_data.node_leaf;
      cmd_item.node_symbol   = req_data.node_symbol;
      cmd_item.code_bit      = req_data.code_bit;
      cmd_push               = 1'b0;
      // unknown codes and writes past the table are dropped here
      unique case (req_data.req_type)
         htd_pkg::REQ_WRITE: begin
            cmd_item.op = htd_pkg::OP_WRITE;
            cmd_push    = accept && in_range;
         end
         htd_pkg::REQ_BIT: begin
            cmd_item.op = htd_pkg::OP_BIT;
            cmd_push    = accept;
         end
         htd_pkg::REQ_END: begin
            cmd_item.op = htd_pkg::OP_END;
            cmd_push    = accept;
         end
         default: begin
            cmd_push = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/core/htd_back.sv -----
module htd_back #(
   parameter int NODE_COUNT  = htd_pkg::NODE_COUNT_DEF,
   parameter int SYMBOL_BITS = htd_pkg::SYMBOL_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  htd_pkg::cmd_item_type      cmd_item,
   output logic                       cmd_pop,
   output logic                       rsp_push,
   output htd_pkg::rsp_item_type      rsp_item,
   input  logic                       rsp_full,
   input  logic                       csr_we,
   input  logic [htd_pkg::IDX_W-1:0]  csr_data
);

   // only the first 2**IDX_W entries can ever be addressed
   localparam int MemDepth = (NODE_COUNT < (1 << htd_pkg::IDX_W)) ?
                             NODE_COUNT : (1 << htd_pkg::IDX_W);
   localparam int AddrW    = $clog2(MemDepth);

   typedef struct packed {
      logic [htd_pkg::IDX_W-1:0] left;
      logic                      left_ok;
      logic [htd_pkg::IDX_W-1:0] right;
      logic                      right_ok;
      logic                      leaf;
      logic [SYMBOL_BITS-1:0]    sym;
   } node_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_LOAD  = 3'b010,
      ST_CHILD = 3'b100
   } state_type;

   node_entry_type node_mem [MemDepth];
   node_entry_type rd_data_ff;
   logic           rd_ok_ff;

   state_type                 state_ff, state_in;
   logic [htd_pkg::IDX_W-1:0] root_ff, root_in;
   logic [htd_pkg::IDX_W-1:0] current_ff, current_in;
   logic [htd_pkg::IDX_W-1:0] next_ff, next_in;
   logic                      cur_valid_ff, cur_valid_in;
   node_entry_type            cur_entry_ff, cur_entry_in;
   logic [htd_pkg::CNT_W-1:0] count_ff, count_in;

   logic                      mem_we;
   node_entry_type            new_entry;
   logic                      rd_en;
   logic [htd_pkg::IDX_W-1:0] rd_idx;
   logic                      rd_in_range;
   node_entry_type            fetched;
   logic [htd_pkg::CNT_W-1:0] count_inc;
   logic [htd_pkg::IDX_W-1:0] child_idx;
   logic                      child_ok;

   assign new_entry.left     = cmd_item.left_index;
   assign new_entry.left_ok  = cmd_item.left_present;
   assign new_entry.right    = cmd_item.right_index;
   assign new_entry.right_ok = cmd_item.right_present;
   assign new_entry.leaf     = cmd_item.node_leaf;
   assign new_entry.sym      = SYMBOL_BITS'(cmd_item.node_symbol);

   // entries past the table read as empty
   assign rd_in_range = (32'(rd_idx) < MemDepth);
   assign fetched     = rd_ok_ff ? rd_data_ff : '0;
   assign count_inc   = (count_ff == htd_pkg::COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign child_idx   = cmd_item.code_bit ? cur_entry_ff.right : cur_entry_ff.left;
   assign child_ok    = cmd_item.code_bit ? cur_entry_ff.right_ok : cur_entry_ff.left_ok;
   assign root_in     = csr_we ? csr_data : root_ff;

   always_comb begin
      state_in     = state_ff;
      current_in   = current_ff;
      next_in      = next_ff;
      cur_valid_in = cur_valid_ff;
      cur_entry_in = cur_entry_ff;
      count_in     = count_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp_item     = '0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      rd_idx       = current_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_item.op)
                  htd_pkg::OP_WRITE: begin
                     mem_we  = 1'b1;
                     cmd_pop = 1'b1;
                     // keep the cached node in step with the table
                     if (cur_valid_ff && (cmd_item.node_index == current_ff)) begin
                        cur_entry_in = new_entry;
                     end
                  end
                  htd_pkg::OP_END: begin
                     if (!rsp_full) begin
                        rsp_push              = 1'b1;
                        rsp_item.result_kind  = htd_pkg::KIND_END;
                        rsp_item.symbol_count = count_ff;
                        count_in              = '0;
                        current_in            = root_ff;
                        cur_valid_in          = 1'b0;
                        cmd_pop               = 1'b1;
                     end
                  end
                  htd_pkg::OP_BIT: begin
                     if (!cur_valid_ff) begin
                        rd_en    = 1'b1;
                        rd_idx   = current_ff;
                        state_in = ST_LOAD;
                     end else if (cur_entry_ff.leaf) begin
                        if (!rsp_full) begin
                           rsp_push              = 1'b1;
                           rsp_item.result_kind  = htd_pkg::KIND_SYMBOL;
                           rsp_item.symbol       = htd_pkg::SYM_W'(cur_entry_ff.sym);
                           rsp_item.symbol_count = count_inc;
                           count_in              = count_inc;
                           current_in            = root_ff;
                           cur_valid_in          = 1'b0;
                           cmd_pop               = 1'b1;
                        end
                     end else if (!child_ok) begin
                        if (!rsp_full) begin
                           rsp_push              = 1'b1;
                           rsp_item.result_kind  = htd_pkg::KIND_ERROR;
                           rsp_item.symbol_count = count_ff;
                           current_in            = root_ff;
                           cur_valid_in          = 1'b0;
                           cmd_pop               = 1'b1;
                        end
                     end else begin
                        rd_en    = 1'b1;
                        rd_idx   = child_idx;
                        next_in  = child_idx;
                        state_in = ST_CHILD;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            cur_entry_in = fetched;
            cur_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_CHILD: begin
            if (fetched.leaf) begin
               if (!rsp_full) begin
                  rsp_push              = 1'b1;
                  rsp_item.result_kind  = htd_pkg::KIND_SYMBOL;
                  rsp_item.symbol       = htd_pkg::SYM_W'(fetched.sym);
                  rsp_item.symbol_count = count_inc;
                  count_in              = count_inc;
                  current_in            = root_ff;
                  cur_valid_in          = 1'b0;
                  cmd_pop               = 1'b1;
                  state_in              = ST_IDLE;
               end
            end else begin
               current_in   = next_ff;
               cur_entry_in = fetched;
               cur_valid_in = 1'b1;
               cmd_pop      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         root_ff      <= '0;
         current_ff   <= '0;
         cur_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         root_ff      <= root_in;
         current_ff   <= current_in;
         cur_valid_ff <= cur_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff      <= next_in;
      cur_entry_ff <= cur_entry_in;
   end

   // node table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[cmd_item.node_index[AddrW-1:0]] <= new_entry;
      end
      if (rd_en) begin
         rd_data_ff <= node_mem[rd_idx[AddrW-1:0]];
         rd_ok_ff   <= rd_in_range;
      end
   end

`ifndef NO_ASSERTIONS
   a_result_retires_item: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> cmd_pop)
      else $error("result pushed without retiring its item");

   // a child result may wait in ST_CHILD while the result queue is full
   a_child_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHILD) |-> ($past(rd_en) || ($past(state_ff) == ST_CHILD)))
      else $error("child evaluated without a table read");

   a_load_fills_cache: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> cur_valid_ff)
      else $error("cache not valid after node load");

   a_symbol_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && (rsp_item.result_kind == htd_pkg::KIND_SYMBOL))
      |-> (rsp_item.symbol_count != '0))
      else $error("symbol reported with zero count");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   // run limits and pacing
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 24;     // bits still in flight after the last result
   localparam int RANDOM_ITEMS  = 1700;
   localparam int PHASE_ITEMS   = 100;

   // request code outside the defined set, the block must drop it
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   localparam logic [htd_pkg::IDX_W-1:0] ROOT_LOW  = '0;
   localparam logic [htd_pkg::IDX_W-1:0] ROOT_HIGH = '1;

   // one entry of the node table as the predictor keeps it
   typedef struct packed {
      logic [htd_pkg::IDX_W-1:0] left;
      logic                      left_ok;
      logic [htd_pkg::IDX_W-1:0] right;
      logic                      right_ok;
      logic                      leaf;
      logic [htd_pkg::SYM_W-1:0] sym;
   } tree_node_type;

   // predictor of the tree walk plus the store of expected results
   class decode_scoreboard;
      tree_node_type             node_mem [htd_pkg::NODE_COUNT_DEF];
      logic [htd_pkg::IDX_W-1:0] root_sel;
      logic [htd_pkg::IDX_W-1:0] walk_pos;
      logic [htd_pkg::CNT_W-1:0] msg_count;
      htd_pkg::rsp_item_type     expected_q [$];
      int                        errors;
      int                        n_symbols;
      int                        n_faults;
      int                        n_ends;
      int                        peak_count;

      function new();
         foreach (node_mem[i]) node_mem[i] = '0;
         root_sel   = '0;
         walk_pos   = '0;
         msg_count  = '0;
         errors     = 0;
         n_symbols  = 0;
         n_faults   = 0;
         n_ends     = 0;
         peak_count = 0;
      endfunction

      function void set_root(logic [htd_pkg::IDX_W-1:0] v);
         root_sel = v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void emit(htd_pkg::kind_type k, logic [htd_pkg::SYM_W-1:0] s);
         htd_pkg::rsp_item_type r;
         r.result_kind  = k;
         r.symbol       = s;
         r.symbol_count = msg_count;
         expected_q.push_back(r);
      endfunction

      function void land_on_leaf(logic [htd_pkg::SYM_W-1:0] s);
         if (msg_count != htd_pkg::COUNT_MAX) msg_count++;
         walk_pos = root_sel;
         emit(htd_pkg::KIND_SYMBOL, s);
      endfunction

      function void note_request(htd_pkg::req_item_type it);
         tree_node_type             here;
         tree_node_type             child;
         logic [htd_pkg::IDX_W-1:0] next_pos;
         logic                      next_ok;
         case (it.req_type)
            htd_pkg::REQ_WRITE: begin
               node_mem[it.node_index] = '{it.left_index, it.left_present, it.right_index,
                                           it.right_present, it.node_leaf, it.node_symbol};
            end
            htd_pkg::REQ_BIT: begin
               here = node_mem[walk_pos];
               if (here.leaf) begin
                  land_on_leaf(here.sym);
               end else begin
                  next_pos = it.code_bit ? here.right : here.left;
                  next_ok  = it.code_bit ? here.right_ok : here.left_ok;
                  if (!next_ok) begin
                     walk_pos = root_sel;
                     emit(htd_pkg::KIND_ERROR, '0);
                  end else begin
                     child = node_mem[next_pos];
                     if (child.leaf) land_on_leaf(child.sym);
                     else walk_pos = next_pos;
                  end
               end
            end
            htd_pkg::REQ_END: begin
               emit(htd_pkg::KIND_END, '0);
               walk_pos  = root_sel;
               msg_count = '0;
            end
            default: ;
         endcase
      endfunction

      function void check_result(htd_pkg::rsp_item_type got);
         htd_pkg::rsp_item_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: kind %0d symbol %02h count %0d",
                     $time, got.result_kind, got.symbol, got.symbol_count);
            return;
         end
         want = expected_q.pop_front();
         case (want.result_kind)
            htd_pkg::KIND_SYMBOL: n_symbols++;
            htd_pkg::KIND_ERROR:  n_faults++;
            default:              n_ends++;
         endcase
         if (int'(got.symbol_count) > peak_count) peak_count = int'(got.symbol_count);
         if (got.result_kind !== want.result_kind) begin
            errors++;
            $display("%0t: result_kind expected %0d actual %0d",
                     $time, want.result_kind, got.result_kind);
         end
         if (got.symbol !== want.symbol) begin
            errors++;
            $display("%0t: symbol expected %02h actual %02h", $time, want.symbol, got.symbol);
         end
         if (got.symbol_count !== want.symbol_count) begin
            errors++;
            $display("%0t: symbol_count expected %0d actual %0d",
                     $time, want.symbol_count, got.symbol_count);
         end
      endfunction
   endclass

   // block ports
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      push  = 1'b0;
   htd_pkg::req_item_type     req_data = '0;
   logic                      full;
   logic                      empty;
   logic                      pop = 1'b0;
   htd_pkg::rsp_item_type     rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [htd_pkg::IDX_W-1:0] csr_data = '0;

   decode_scoreboard sb = new();

   // stimulus waiting for the request side and its bookkeeping
   htd_pkg::req_item_type     stim_q [$];
   int                        items_queued = 0;   // every item handed to the driver
   int                        items_taken  = 0;   // every item the block accepted
   int                        items_made   = 0;   // items that are not dropped by the block
   int                        roots_written = 0;
   logic [htd_pkg::IDX_W-1:0] tree_nodes [$];     // entries of the tree currently loaded
   bit                        req_taken = 1'b0;
   int                        burst_left = 0;
   int                        gap_left   = 0;
   logic [15:0]               pop_pattern = '1;
   int                        pat_left = 0;
   int                        cycle_count = 0;

   huffman_tree_decoder_core uut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, sb.pending());
         $display("simulation failed");
         $finish;
      end
   end

   // sample all three handshakes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            sb.note_request(req_data);
            items_taken++;
            req_taken = 1'b1;
         end
         if (pop && !empty) sb.check_result(rsp_data);
         if (csr_valid && csr_ready) sb.set_root(csr_data);
      end
   end

   // request driver: bursts of random length with random gaps in between
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_taken) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            push <= 1'b0;
         end else if (stim_q.size() != 0) begin
            req_data <= stim_q.pop_front();
            push     <= 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               // a quarter of the bursts run straight into the next one
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            push <= 1'b0;
         end
      end
   end

   // result side: pop follows a rotating pattern that is redrawn now and then
   always @(negedge clock) begin
      if (pat_left == 0) begin
         case ($urandom_range(0, 3))
            0:       pop_pattern = '1;                        // no stalls
            1:       pop_pattern = 16'h0001;                  // long stalls
            default: pop_pattern = 16'($urandom) | 16'h0001;  // scattered stalls
         endcase
         pat_left = $urandom_range(50, 300);
      end
      pop <= pop_pattern[0];
      pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
      pat_left--;
   end

   // item builders, fields that the request does not use stay random
   function automatic htd_pkg::req_item_type node_write(
      logic [htd_pkg::IDX_W-1:0] idx, logic [htd_pkg::IDX_W-1:0] l, logic lp,
      logic [htd_pkg::IDX_W-1:0] r, logic rp, logic leaf, logic [htd_pkg::SYM_W-1:0] sym);
      htd_pkg::req_item_type it;
      it               = htd_pkg::req_item_type'($urandom);
      it.req_type      = htd_pkg::REQ_WRITE;
      it.node_index    = idx;
      it.left_index    = l;
      it.left_present  = lp;
      it.right_index   = r;
      it.right_present = rp;
      it.node_leaf     = leaf;
      it.node_symbol   = sym;
      return it;
   endfunction

   function automatic htd_pkg::req_item_type random_write(logic [htd_pkg::IDX_W-1:0] idx);
      htd_pkg::req_item_type it;
      it            = htd_pkg::req_item_type'($urandom);
      it.req_type   = htd_pkg::REQ_WRITE;
      it.node_index = idx;
      return it;
   endfunction

   function automatic htd_pkg::req_item_type code_bit_item(logic b);
      htd_pkg::req_item_type it;
      it          = htd_pkg::req_item_type'($urandom);
      it.req_type = htd_pkg::REQ_BIT;
      it.code_bit = b;
      return it;
   endfunction

   function automatic htd_pkg::req_item_type coded_item(logic [1:0] code);
      htd_pkg::req_item_type it;
      it          = htd_pkg::req_item_type'($urandom);
      it.req_type = code;
      return it;
   endfunction

   task automatic add(htd_pkg::req_item_type it);
      stim_q.push_back(it);
      items_queued++;
      if (it.req_type != REQ_UNKNOWN) items_made++;
   endtask

   // wait until every item is taken and every result is back, then let
   // a bit that gives no result finish its walk
   task automatic drain();
      while (items_taken != items_queued) @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // root register write, only called with the block idle
   task automatic write_root(logic [htd_pkg::IDX_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      roots_written++;
   endtask

   // full binary tree grown from the root; chain mode keeps growing the newest
   // node to get deep codes, and now and then an inner node loses a child
   task automatic load_tree(logic [htd_pkg::IDX_W-1:0] root, int n_inner, bit chain);
      logic [htd_pkg::IDX_W-1:0] pool [$];
      logic [htd_pkg::IDX_W-1:0] open_q [$];
      logic [htd_pkg::IDX_W-1:0] nd, l, r, t;
      logic                      lp, rp;
      int                        p, j;
      for (int i = 0; i < htd_pkg::NODE_COUNT_DEF; i++)
         if (i != int'(root)) pool.push_back(htd_pkg::IDX_W'(i));
      for (int i = pool.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = pool[i];
         pool[i] = pool[j];
         pool[j] = t;
      end
      tree_nodes.delete();
      open_q.push_back(root);
      for (int k = 0; k < n_inner; k++) begin
         p  = chain ? open_q.size() - 1 : $urandom_range(0, open_q.size() - 1);
         nd = open_q[p];
         open_q.delete(p);
         l  = pool.pop_back();
         r  = pool.pop_back();
         lp = 1'b1;
         rp = 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1)) lp = 1'b0;
            else rp = 1'b0;
         end
         add(node_write(nd, l, lp, r, rp, 1'b0, htd_pkg::SYM_W'($urandom_range(0, 255))));
         tree_nodes.push_back(nd);
         open_q.push_back(l);
         open_q.push_back(r);
      end
      // leaves keep random child fields, the leaf flag must win over them
      foreach (open_q[i]) begin
         add(node_write(open_q[i], htd_pkg::IDX_W'($urandom_range(0, 63)),
                        1'($urandom_range(0, 1)), htd_pkg::IDX_W'($urandom_range(0, 63)),
                        1'($urandom_range(0, 1)), 1'b1,
                        htd_pkg::SYM_W'($urandom_range(0, 255))));
         tree_nodes.push_back(open_q[i]);
      end
   endtask

   initial begin
      int                        phase;
      int                        n_inner;
      int                        pick;
      logic [htd_pkg::IDX_W-1:0] new_root;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: small hand-built tree under root 0
      add(node_write(6'd0, 6'd1, 1'b1, 6'd2, 1'b1, 1'b0, 8'h5a));
      add(node_write(6'd1, 6'd63, 1'b0, 6'd0, 1'b0, 1'b1, 8'hff));
      add(node_write(6'd2, 6'd3, 1'b1, 6'd0, 1'b0, 1'b0, 8'h00));   // right child missing
      add(node_write(6'd3, 6'd0, 1'b0, 6'd0, 1'b0, 1'b1, 8'h00));
      add(node_write(6'd63, 6'd63, 1'b1, 6'd63, 1'b1, 1'b1, 8'ha5)); // leaf with all fields set
      add(node_write(6'd62, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0, 8'h00));   // inner node, no children
      add(code_bit_item(1'b0));                                       // symbol ff
      add(code_bit_item(1'b1));
      add(code_bit_item(1'b0));                                       // symbol 00
      add(code_bit_item(1'b1));
      add(code_bit_item(1'b1));                                       // missing child
      add(coded_item(REQ_UNKNOWN));                                   // dropped
      add(coded_item(htd_pkg::REQ_END));
      add(code_bit_item(1'b1));                                       // walk parked on node 2
      drain();

      // root moves while a walk is in progress: walk finishes from node 2
      write_root(ROOT_HIGH);
      add(code_bit_item(1'b0));                                       // leaf 3, back to leaf root
      add(code_bit_item(1'b1));                                       // root itself is a leaf
      drain();
      write_root(6'd62);
      add(coded_item(htd_pkg::REQ_END));
      add(code_bit_item(1'b0));                                       // childless inner root
      drain();
      write_root(ROOT_LOW);
      add(code_bit_item(1'b1));                                       // still at 62, error again
      add(node_write(6'd1, 6'd0, 1'b1, 6'd0, 1'b1, 1'b1, 8'h81));
      add(code_bit_item(1'b0));
      add(code_bit_item(1'b1));
      add(node_write(6'd2, 6'd0, 1'b1, 6'd0, 1'b1, 1'b1, 8'h3c));   // current node turns leaf
      add(code_bit_item(1'b0));
      add(coded_item(htd_pkg::REQ_END));

      // every entry gets written so no walk can read a stale one
      for (int i = 0; i < htd_pkg::NODE_COUNT_DEF; i++) add(random_write(htd_pkg::IDX_W'(i)));

      // random phases: new root, fresh tree, then mostly code bits
      phase = 0;
      RANDOM_ITEMS_LOOP: while (items_made < RANDOM_ITEMS - PHASE_ITEMS) begin
         drain();
         case (phase % 4)
            0:       new_root = ROOT_LOW;
            1:       new_root = ROOT_HIGH;
            default: new_root = htd_pkg::IDX_W'($urandom_range(0, 63));
         endcase
         write_root(new_root);
         case ($urandom_range(0, 7))
            0:       n_inner = 0;       // single leaf root
            1:       n_inner = 31;      // 63 of the 64 entries in the tree
            default: n_inner = $urandom_range(1, 15);
         endcase
         load_tree(new_root, n_inner, $urandom_range(0, 2) == 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) add(code_bit_item(1'($urandom_range(0, 1))));
            else if (pick < 86) add(coded_item(htd_pkg::REQ_END));   // cuts a code short
            else if (pick < 90) add(coded_item(REQ_UNKNOWN));
            else if (pick < 95)
               add(random_write(tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]));
            else add(random_write(htd_pkg::IDX_W'($urandom_range(0, 63))));
         end
         phase++;
      end
      drain();

      $display("covered %0d items over %0d root settings: %0d symbols, %0d missing-child errors",
               items_taken, roots_written, sb.n_symbols, sb.n_faults);
      $display("%0d end reports, message count peaked at %0d", sb.n_ends, sb.peak_count);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
         $display("simulation failed");
      end
      $finish;
   end

endmodule
